>>> rtl/core/ctcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctcr_pkg: shared constants for the circle/tile collision resolver
// Widths of the position words and configuration registers, register indexes.
// ----------------------------------------------------------------------------
package ctcr_pkg;

  localparam int POS_WIDTH = 32;
  localparam int FRAC_BITS = 16;

  // configuration register widths
  localparam int CFG_W   = 17;
  localparam int FLOOR_W = 9;
  localparam int ADDR_W  = 2;
  localparam int MASK_W  = 9;

  typedef enum logic [ADDR_W-1:0] {
    REG_TILE_HALF   = 2'd0,
    REG_BODY_RADIUS = 2'd1,
    REG_FLOOR_COUNT = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_W-1:0]   TILE_HALF_RST   = 17'd32768;
  localparam logic [CFG_W-1:0]   BODY_RADIUS_RST = 17'd16384;
  localparam logic [FLOOR_W-1:0] FLOOR_COUNT_RST = 9'd1;

endpackage

>>> rtl/core/ctcr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctcr_in_if: body position word channel
// Valid/ready channel carrying one body position and its solid mask.
// ----------------------------------------------------------------------------
interface ctcr_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ctcr_pkg::POS_WIDTH-1:0]  pos_x;
  logic signed [ctcr_pkg::POS_WIDTH-1:0]  pos_y;
  logic signed [ctcr_pkg::POS_WIDTH-1:0]  pos_z;
  logic        [ctcr_pkg::MASK_W-1:0]     solid_mask;

  modport source (output valid, pos_x, pos_y, pos_z, solid_mask, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, solid_mask, output ready);
endinterface

>>> rtl/core/ctcr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctcr_out_if: resolved position word channel
// Valid/ready channel carrying the resolved position and push flag.
// ----------------------------------------------------------------------------
interface ctcr_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ctcr_pkg::POS_WIDTH-1:0]  new_x;
  logic signed [ctcr_pkg::POS_WIDTH-1:0]  new_y;
  logic                                   pushed;

  modport source (output valid, new_x, new_y, pushed, input ready);
  modport sink   (input valid, new_x, new_y, pushed, output ready);
endinterface

>>> rtl/core/ctcr_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctcr_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ctcr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ctcr_pkg::ADDR_W-1:0]       addr;
  logic [ctcr_pkg::CFG_W-1:0]        data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

>>> rtl/core/circle_tile_collision_resolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_tile_collision_resolve: push a circular body out of solid tiles
// Sequencer around one shared shift/subtract unit (square root and divide)
// and one 17x17 multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_s   : one word per body (pos_x, pos_y, pos_z, solid_mask). Taken only
//            while the resolver is idle; in_s.ready stays low during work.
//   out_m  : one word per input (new_x, new_y, pushed), held in an output
//            register until taken. A new input may be taken while it waits.
//   cfg_s  : register writes, always ready; write only while idle.
// Work per input word, in order: a scan of the tile slots up to the last
//   solid one; for each solid tile a clamp, which drops the tile if it is
//   out of reach, then two squares, 17 root steps and a distance check,
//   which drops the tile unless it pushes; a pushing tile then takes a
//   multiply and 36 divide steps on the shared shift/subtract unit for
//   each axis, and a position update.
//   A floor out of range empties the mask; the position passes through.
//   One word is worked on at a time; the shared unit sets the rate.
// Reset (rst_n low, synchronous): sequencer idle, output word dropped,
// registers back to their defaults. If the receiver stalls, the finished
// word waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module circle_tile_collision_resolve (
  input  logic         clk,
  input  logic         rst_n,
  ctcr_in_if.sink      in_s,
  ctcr_out_if.source   out_m,
  ctcr_cfg_if.sink     cfg_s
);
  import ctcr_pkg::*;

  localparam int W      = POS_WIDTH;
  localparam int EW     = POS_WIDTH + 4;         // room for tile centers and sums
  localparam int SQW    = 2 * CFG_W;             // sum of two squares
  localparam int NW     = 2 * CFG_W + 2;         // divide numerator
  localparam int REMW   = CFG_W + 3;             // partial remainder
  localparam int CNT_W  = $clog2(NW);
  localparam logic [CNT_W-1:0] SQ_LAST  = CNT_W'(CFG_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NW - 1);
  localparam logic signed [EW-1:0] UNIT = EW'(1) << FRAC_BITS;
  localparam logic signed [EW-1:0] HALF = EW'(1) << (FRAC_BITS - 1);
  localparam logic signed [W+1:0] SUM_MAX = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [W+1:0] SUM_MIN = {3'b111, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_CLAMP, ST_SQX, ST_SQY, ST_SQRT, ST_CHK,
    ST_MULX, ST_DIVX, ST_MULY, ST_DIVY, ST_APPLY, ST_FIN
  } state_t;

  state_t                  state_r;
  logic [CFG_W-1:0]        half_r, radius_r;
  logic [FLOOR_W-1:0]      floors_r;
  logic signed [W-1:0]     px_r, py_r;
  logic signed [EW-1:0]    base_x_r, base_y_r;
  logic [MASK_W-1:0]       mask_r;
  logic [1:0]              col_r, row_r;
  logic                    sx_r, sy_r;
  logic [CFG_W-1:0]        ax_r, ay_r;
  logic [SQW-1:0]          acc_r;
  logic [NW-1:0]           src_r;
  logic [REMW-1:0]         rem_r;
  logic [CFG_W:0]          res_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [CFG_W-1:0]        dist_r;
  logic [CFG_W:0]          qx_r;
  logic                    pushed_r;
  logic                    out_valid_r;
  logic signed [W-1:0]     out_x_r, out_y_r;
  logic                    out_pushed_r;

  // --- rounding of the input position to the nearest tile, times UNIT ---
  function automatic logic signed [EW-1:0] tile_base(input logic signed [W-1:0] p);
    logic signed [EW-1:0] pe;
    logic signed [EW-1:0] t;
    pe = EW'(p);
    if (p >= 0) t = (pe + HALF) >>> FRAC_BITS;
    else        t = -((-pe + HALF) >>> FRAC_BITS);
    return t <<< FRAC_BITS;
  endfunction

  // floor(z) inside 0..floor_count-1
  logic floor_ok;
  assign floor_ok = !in_s.pos_z[W-1] &&
                    ({{FLOOR_W{1'b0}}, in_s.pos_z[W-1:FRAC_BITS]} <
                     (W-FRAC_BITS+FLOOR_W)'(floors_r));

  // --- clamp of the position to the current tile square ---
  function automatic logic signed [EW-1:0] tile_off(input logic [1:0] k);
    unique case (k)
      2'd0:    return -UNIT;
      2'd1:    return '0;
      default: return UNIT;
    endcase
  endfunction

  logic signed [EW-1:0] cx, cy, pxe, pye, he, ox, oy, mx, my;
  always_comb begin
    he  = EW'(half_r);
    pxe = EW'(px_r);
    pye = EW'(py_r);
    cx  = base_x_r + tile_off(col_r);
    cy  = base_y_r + tile_off(row_r);
    if (pxe < cx - he)      ox = pxe - (cx - he);
    else if (pxe > cx + he) ox = pxe - (cx + he);
    else                    ox = '0;
    if (pye < cy - he)      oy = pye - (cy - he);
    else if (pye > cy + he) oy = pye - (cy + he);
    else                    oy = '0;
    mx = ox[EW-1] ? -ox : ox;
    my = oy[EW-1] ? -oy : oy;
  end

  logic in_reach;
  assign in_reach = (mx <= EW'(radius_r)) && (my <= EW'(radius_r));

  // --- shared multiplier ---
  logic [CFG_W-1:0] mul_a, mul_b, depth;
  logic [SQW-1:0]   prod;
  assign depth = radius_r - dist_r;
  always_comb begin
    unique case (state_r)
      ST_SQX:  begin mul_a = ax_r; mul_b = ax_r;  end
      ST_SQY:  begin mul_a = ay_r; mul_b = ay_r;  end
      ST_MULX: begin mul_a = ax_r; mul_b = depth; end
      default: begin mul_a = ay_r; mul_b = depth; end
    endcase
  end
  assign prod = mul_a * mul_b;

  logic [NW-1:0] num;
  assign num = NW'({prod, 1'b0}) + NW'(dist_r);

  // --- shared shift/subtract unit: root digit or quotient bit per cycle ---
  logic            is_root;
  logic [REMW-1:0] shifted, trial, rem_nxt;
  logic            ge;
  assign is_root = (state_r == ST_SQRT);
  always_comb begin
    if (is_root) begin
      shifted = {rem_r[REMW-3:0], src_r[NW-1 -: 2]};
      trial   = {{(REMW-CFG_W-2){1'b0}}, res_r[CFG_W-1:0], 2'b01};
    end else begin
      shifted = {rem_r[REMW-2:0], src_r[NW-1]};
      trial   = {{(REMW-CFG_W-1){1'b0}}, dist_r, 1'b0};
    end
    ge      = shifted >= trial;
    rem_nxt = ge ? shifted - trial : shifted;
  end

  logic [CFG_W:0] res_nxt;
  assign res_nxt = {res_r[CFG_W-1:0], ge};

  // --- position update with saturation ---
  logic signed [W+1:0] sum_x, sum_y, push_x, push_y;
  logic signed [W-1:0] sat_x, sat_y;
  always_comb begin
    push_x = sx_r ? -(W+2)'(qx_r)  : (W+2)'(qx_r);
    push_y = sy_r ? -(W+2)'(res_r) : (W+2)'(res_r);
    sum_x  = (W+2)'(px_r) + push_x;
    sum_y  = (W+2)'(py_r) + push_y;
    if (sum_x > SUM_MAX)      sat_x = SUM_MAX[W-1:0];
    else if (sum_x < SUM_MIN) sat_x = SUM_MIN[W-1:0];
    else                      sat_x = sum_x[W-1:0];
    if (sum_y > SUM_MAX)      sat_y = SUM_MAX[W-1:0];
    else if (sum_y < SUM_MIN) sat_y = SUM_MIN[W-1:0];
    else                      sat_y = sum_y[W-1:0];
  end

  // next tile slot: column outer, row inner
  logic [MASK_W-1:0] mask_adv;
  logic [1:0]        col_adv, row_adv;
  assign mask_adv = mask_r >> 1;
  assign row_adv  = (row_r == 2'd2) ? 2'd0 : row_r + 2'd1;
  assign col_adv  = (row_r == 2'd2) ? col_r + 2'd1 : col_r;

  assign in_s.ready  = (state_r == ST_IDLE);
  assign cfg_s.ready = 1'b1;
  assign out_m.valid  = out_valid_r;
  assign out_m.new_x  = out_x_r;
  assign out_m.new_y  = out_y_r;
  assign out_m.pushed = out_pushed_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r   <= TILE_HALF_RST;
      radius_r <= BODY_RADIUS_RST;
      floors_r <= FLOOR_COUNT_RST;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.addr)
        REG_TILE_HALF:   half_r   <= cfg_s.data;
        REG_BODY_RADIUS: radius_r <= cfg_s.data;
        REG_FLOOR_COUNT: floors_r <= cfg_s.data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // drop a taken word; in ST_FIN the output register is reloaded below
      if (out_valid_r && out_m.ready && state_r != ST_FIN) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_s.valid) begin
            px_r     <= in_s.pos_x;
            py_r     <= in_s.pos_y;
            base_x_r <= tile_base(in_s.pos_x);
            base_y_r <= tile_base(in_s.pos_y);
            // floor out of range: empty mask, position passes through
            mask_r   <= floor_ok ? in_s.solid_mask : '0;
            col_r    <= 2'd0;
            row_r    <= 2'd0;
            pushed_r <= 1'b0;
            state_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (mask_r == '0) begin
            state_r <= ST_FIN;
          end else if (mask_r[0]) begin
            state_r <= ST_CLAMP;
          end else begin
            mask_r <= mask_adv;
            col_r  <= col_adv;
            row_r  <= row_adv;
          end
        end
        ST_CLAMP: begin
          sx_r <= ox[EW-1];
          sy_r <= oy[EW-1];
          ax_r <= mx[CFG_W-1:0];
          ay_r <= my[CFG_W-1:0];
          if (in_reach) begin
            state_r <= ST_SQX;
          end else begin
            mask_r  <= mask_adv;
            col_r   <= col_adv;
            row_r   <= row_adv;
            state_r <= ST_SCAN;
          end
        end
        ST_SQX: begin
          acc_r   <= prod;
          state_r <= ST_SQY;
        end
        ST_SQY: begin
          src_r   <= {acc_r + prod, 2'b00};
          rem_r   <= '0;
          res_r   <= '0;
          cnt_r   <= SQ_LAST;
          state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          src_r <= src_r << 2;
          rem_r <= rem_nxt;
          res_r <= res_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            dist_r  <= res_nxt[CFG_W-1:0];
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (dist_r == '0 || dist_r >= radius_r) begin
            mask_r  <= mask_adv;
            col_r   <= col_adv;
            row_r   <= row_adv;
            state_r <= ST_SCAN;
          end else begin
            state_r <= ST_MULX;
          end
        end
        ST_MULX, ST_MULY: begin
          src_r   <= num;
          rem_r   <= '0;
          res_r   <= '0;
          cnt_r   <= DIV_LAST;
          state_r <= (state_r == ST_MULX) ? ST_DIVX : ST_DIVY;
        end
        ST_DIVX, ST_DIVY: begin
          src_r <= src_r << 1;
          rem_r <= rem_nxt;
          res_r <= res_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            if (state_r == ST_DIVX) begin
              qx_r    <= res_nxt;
              state_r <= ST_MULY;
            end else begin
              state_r <= ST_APPLY;
            end
          end
        end
        ST_APPLY: begin
          px_r     <= sat_x;
          py_r     <= sat_y;
          pushed_r <= 1'b1;
          mask_r   <= mask_adv;
          col_r    <= col_adv;
          row_r    <= row_adv;
          state_r  <= ST_SCAN;
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!out_valid_r || out_m.ready) begin
            out_x_r      <= px_r;
            out_y_r      <= py_r;
            out_pushed_r <= pushed_r;
            out_valid_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/ctcr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctcr_checker: port-level checks for the collision resolver
// Watches the input and output channels of the top level over time; attached by bind.
// ----------------------------------------------------------------------------
module ctcr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [ctcr_pkg::POS_WIDTH-1:0] new_x,
  input logic signed [ctcr_pkg::POS_WIDTH-1:0] new_y,
  input logic                               pushed
);
  import ctcr_pkg::*;

  // an accepted word makes the resolver busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready after accept");

  // a new result only comes out of a busy resolver
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work in progress");

  // drop the output word on reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(new_x) && $stable(new_y) && $stable(pushed)))
    else $error("stalled result changed");

endmodule

bind circle_tile_collision_resolve ctcr_checker u_ctcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .new_x     (out_m.new_x),
  .new_y     (out_m.new_y),
  .pushed    (out_m.pushed)
);

>>> verif/ctcr_resolve_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctcr_resolve_checker: push-out predictor and result comparator
// Watches the position, result and register channels. It mirrors the
// registers, predicts each resolved position and compares the results in order.
// ----------------------------------------------------------------------------
module ctcr_resolve_checker (
  input  logic       clk,
  input  logic       rst_n,
  ctcr_in_if.sink    in_w,
  ctcr_out_if.sink   out_w,
  ctcr_cfg_if.sink   cfg_w,
  output int         fail_count,
  output int         pending
);
  import ctcr_pkg::*;

  typedef struct packed {
    logic signed [POS_WIDTH-1:0] x;
    logic signed [POS_WIDTH-1:0] y;
    logic                        pushed;
  } resolved_t;

  resolved_t         want_q[$];
  logic [CFG_W-1:0]   half_r;
  logic [CFG_W-1:0]   radius_r;
  logic [FLOOR_W-1:0] floors_r;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint tile_index(longint p);
    longint half;
    half = 64'sd1 <<< (FRAC_BITS - 1);
    if (p >= 0) return (p + half) >>> FRAC_BITS;
    return -((-p + half) >>> FRAC_BITS);
  endfunction

  function automatic longint clip(longint p, longint lo, longint hi);
    if (p < lo) return lo;
    if (p > hi) return hi;
    return p;
  endfunction

  function automatic longint push_amount(longint d, longint depth, longint span);
    longint q;
    q = (2 * abs_l(d) * depth + span) / (2 * span);
    return (d < 0) ? -q : q;
  endfunction

  function automatic longint sat(longint v);
    longint hi;
    hi = (64'sd1 <<< (POS_WIDTH - 1)) - 1;
    return clip(v, -hi - 1, hi);
  endfunction

  function automatic resolved_t resolve(logic signed [POS_WIDTH-1:0] ix,
                                        logic signed [POS_WIDTH-1:0] iy,
                                        logic signed [POS_WIDTH-1:0] iz,
                                        logic [MASK_W-1:0] mask);
    resolved_t res;
    longint px, py, pz, rx, ry, h, r, cx, cy, ox, oy, span;
    px = ix; py = iy; pz = iz;
    h = half_r; r = radius_r;
    res.pushed = 1'b0;
    if (pz >= 0 && (pz >>> FRAC_BITS) < longint'(floors_r)) begin
      rx = tile_index(px);
      ry = tile_index(py);
      for (int dx = -1; dx <= 1; dx++) begin
        for (int dy = -1; dy <= 1; dy++) begin
          if (mask[(dx + 1) * 3 + dy + 1]) begin
            cx = (rx + dx) <<< FRAC_BITS;
            cy = (ry + dy) <<< FRAC_BITS;
            ox = px - clip(px, cx - h, cx + h);
            oy = py - clip(py, cy - h, cy + h);
            if (abs_l(ox) <= r && abs_l(oy) <= r) begin
              span = root_floor(ox * ox + oy * oy);
              if (span != 0 && span < r) begin
                px = sat(px + push_amount(ox, r - span, span));
                py = sat(py + push_amount(oy, r - span, span));
                res.pushed = 1'b1;
              end
            end
          end
        end
      end
    end
    res.x = px[POS_WIDTH-1:0];
    res.y = py[POS_WIDTH-1:0];
    return res;
  endfunction

  assign pending = want_q.size();

  always @(posedge clk) begin
    resolved_t got;
    resolved_t want;
    if (!rst_n) begin
      half_r     <= TILE_HALF_RST;
      radius_r   <= BODY_RADIUS_RST;
      floors_r   <= FLOOR_COUNT_RST;
      fail_count <= 0;
      want_q.delete();
    end else begin
      if (cfg_w.valid && cfg_w.ready) begin
        case (cfg_reg_t'(cfg_w.addr))
          REG_TILE_HALF:   half_r   <= cfg_w.data;
          REG_BODY_RADIUS: radius_r <= cfg_w.data;
          REG_FLOOR_COUNT: floors_r <= cfg_w.data[FLOOR_W-1:0];
          default: ;
        endcase
      end
      if (in_w.valid && in_w.ready)
        want_q.push_back(resolve(in_w.pos_x, in_w.pos_y, in_w.pos_z, in_w.solid_mask));
      if (out_w.valid && out_w.ready) begin
        got = '{out_w.new_x, out_w.new_y, out_w.pushed};
        if (want_q.size() == 0) begin
          $error("result word with no expectation: x=%0d y=%0d", got.x, got.y);
          fail_count <= fail_count + 1;
        end else begin
          want = want_q.pop_front();
          if (got.x !== want.x) $error("new_x: expected %0d, got %0d", want.x, got.x);
          if (got.y !== want.y) $error("new_y: expected %0d, got %0d", want.y, got.y);
          if (got.pushed !== want.pushed)
            $error("pushed: expected %0b, got %0b", want.pushed, got.pushed);
          if (got !== want) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

>>> verif/tb_circle_tile_collision_resolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_tile_collision_resolve: stimulus and verdict for the resolver
// Drives directed and random body words under several register settings,
// with random gaps and stalls. The checker does the predicting and comparing.
// ----------------------------------------------------------------------------
module tb_circle_tile_collision_resolve;
  import ctcr_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  bit   hold_off;   // forces the receiver into a long stall

  ctcr_in_if  in_c ();
  ctcr_out_if out_c ();
  ctcr_cfg_if cfg_c ();

  circle_tile_collision_resolve dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_c.sink), .out_m(out_c.source), .cfg_s(cfg_c.sink)
  );

  ctcr_resolve_checker chk (
    .clk(clk), .rst_n(rst_n), .in_w(in_c.sink), .out_w(out_c.sink),
    .cfg_w(cfg_c.sink), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort the run if it has not ended by the cycle limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Pick a gap length: mostly none or short, sometimes long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Receiver: random stalls, plus a long hold while hold_off is set.
  initial begin
    int n;
    out_c.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_c.ready = 1'b0;
      end else if (out_c.ready && $urandom_range(9) < 8) begin
        // stay ready for a stretch
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_c.ready = 1'b0;
          repeat (n - 1) @(negedge clk);
          @(negedge clk);
        end
        out_c.ready = 1'b1;
      end
    end
  end

  // Write one register while the block is idle.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_c.addr  = idx;
    cfg_c.data  = val;
    cfg_c.valid = 1'b1;
    do @(posedge clk); while (!cfg_c.ready);
    @(negedge clk);
    cfg_c.valid = 1'b0;
  endtask

  // Offer one body word and wait for acceptance; leaves valid low after it.
  task automatic send_body(logic signed [POS_WIDTH-1:0] x, logic signed [POS_WIDTH-1:0] y,
                           logic signed [POS_WIDTH-1:0] z, logic [MASK_W-1:0] m,
                           bit gaps);
    int n;
    in_c.pos_x = x;
    in_c.pos_y = y;
    in_c.pos_z = z;
    in_c.solid_mask = m;
    in_c.valid = 1'b1;
    do @(posedge clk); while (!in_c.ready);
    @(negedge clk);
    in_c.valid = 1'b0;
    n = gaps ? gap_len() : 0;
    repeat (n) @(negedge clk);
  endtask

  // Hold until every expected word has arrived, then let the block settle.
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Random position: mostly near the origin, sometimes anywhere in range.
  function automatic logic signed [POS_WIDTH-1:0] rand_pos();
    if ($urandom_range(9) == 0) return $urandom;
    return $signed($urandom_range(0, 20 << FRAC_BITS)) - (10 <<< FRAC_BITS);
  endfunction

  // Floor position mostly from 0 to 3 units, sometimes negative or anywhere.
  function automatic logic signed [POS_WIDTH-1:0] rand_floor();
    int p;
    p = $urandom_range(9);
    if (p < 7) return $urandom_range(0, 3 << FRAC_BITS);
    if (p < 8) return -$signed($urandom_range(1, 1 << FRAC_BITS));
    return $urandom;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      send_body(rand_pos(), rand_pos(), rand_floor(), MASK_W'($urandom_range(511)), 1'b1);
  endtask

  localparam logic signed [POS_WIDTH-1:0] P_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] P_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
  localparam logic signed [POS_WIDTH-1:0] ONE   = 1 <<< FRAC_BITS;

  initial begin
    hold_off = 1'b0;
    in_c.valid = 1'b0;
    in_c.pos_x = '0;
    in_c.pos_y = '0;
    in_c.pos_z = '0;
    in_c.solid_mask = '0;
    cfg_c.valid = 1'b0;
    cfg_c.addr = REG_TILE_HALF;
    cfg_c.data = '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words at reset settings.
    send_body(0, 0, 0, 9'h1ff, 1'b0);                       // zero distance
    send_body(ONE / 2, ONE / 4, 0, 9'h1ff, 1'b0);           // rounding tie
    send_body(-ONE / 2, -ONE / 4, 0, 9'h1ff, 1'b0);
    send_body(ONE / 2 - 100, 300, 0, 9'h010, 1'b0);         // centre tile only
    send_body(ONE / 2 + 8000, 9000, 0, 9'h1ff, 1'b0);       // side push
    send_body(P_MAX, P_MAX, 0, 9'h1ff, 1'b0);               // top of range
    send_body(P_MIN, P_MIN, 0, 9'h1ff, 1'b0);               // bottom of range
    send_body(ONE / 2 + 9000, 0, -1, 9'h1ff, 1'b0);         // floor negative
    send_body(ONE / 2 + 9000, 0, ONE, 9'h1ff, 1'b0);        // floor too high
    send_body(ONE / 2 + 9000, 0, P_MAX, 9'h1ff, 1'b0);
    send_body(ONE / 2 + 9000, 0, ONE - 1, 9'h000, 1'b0);    // nothing solid
    for (int b = 0; b < MASK_W; b++)
      send_body(ONE / 2 + 6000, ONE / 2 + 7000, 0, 9'(1 << b), 1'b0);
    drain();

    // Half width and radius of one unit with 256 floors, then zero settings.
    write_reg(REG_TILE_HALF, 17'd65536);
    write_reg(REG_BODY_RADIUS, 17'd65536);
    write_reg(REG_FLOOR_COUNT, 17'd256);
    send_body(ONE / 3, -ONE / 5, 255 <<< FRAC_BITS, 9'h1ff, 1'b0);
    send_body(P_MAX - 5, P_MIN + 5, 0, 9'h1ff, 1'b0);
    random_phase(120);
    drain();

    write_reg(REG_TILE_HALF, 17'd0);
    write_reg(REG_BODY_RADIUS, 17'd0);
    write_reg(REG_FLOOR_COUNT, 17'd0);
    random_phase(40);
    drain();

    write_reg(REG_FLOOR_COUNT, 17'd4);
    write_reg(REG_BODY_RADIUS, 17'd0);
    random_phase(40);
    drain();

    // Stall the receiver for a long stretch while words keep coming.
    write_reg(REG_TILE_HALF, 17'd20000);
    write_reg(REG_BODY_RADIUS, 17'd40000);
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end
      random_phase(20);
    join
    drain();

    for (int k = 0; k < 4; k++) begin
      write_reg(REG_TILE_HALF, CFG_W'($urandom_range(65536)));
      write_reg(REG_BODY_RADIUS, CFG_W'($urandom_range(65536)));
      write_reg(REG_FLOOR_COUNT, CFG_W'($urandom_range(1, 256)));
      random_phase(110);
      drain();
    end

    // Back-to-back, no input gaps.
    for (int i = 0; i < 40; i++)
      send_body(rand_pos(), rand_pos(), 0, MASK_W'($urandom_range(511)), 1'b0);
    drain();

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ctcr_pkg.sv
rtl/core/ctcr_in_if.sv
rtl/core/ctcr_out_if.sv
rtl/core/ctcr_cfg_if.sv
rtl/core/circle_tile_collision_resolve.sv
rtl/core/ctcr_checker.sv
verif/ctcr_resolve_checker.sv
verif/tb_circle_tile_collision_resolve.sv
